>>> rtl/aeng_pkg.sv
// Package for the archive entry name guard.
// Holds request and verdict types, the classified byte type, reason codes and
// character constants. No dependencies.
package aeng_pkg;

	localparam int NAME_LIMIT_DEF = 4096;
	localparam int MAX_LEN_W      = 13;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(4096);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CASE_GAP  = 8'h20;

	localparam logic [23:0] DEV_CON = "CON";
	localparam logic [23:0] DEV_PRN = "PRN";
	localparam logic [23:0] DEV_AUX = "AUX";
	localparam logic [23:0] DEV_NUL = "NUL";
	localparam logic [23:0] DEV_COM = "COM";
	localparam logic [23:0] DEV_LPT = "LPT";

	typedef enum logic [3:0] {
		REASON_OK       = 4'd0,
		REASON_EMPTY    = 4'd1,
		REASON_TOO_LONG = 4'd2,
		REASON_NUL      = 4'd3,
		REASON_ABSOLUTE = 4'd4,
		REASON_DRIVE    = 4'd5,
		REASON_PARENT   = 4'd6,
		REASON_TRAILING = 4'd7,
		REASON_DEVICE   = 4'd8
	} reason_t;

	typedef enum logic [1:0] {
		FAULT_NONE     = 2'd0,
		FAULT_PARENT   = 2'd1,
		FAULT_TRAILING = 2'd2,
		FAULT_DEVICE   = 2'd3
	} fault_t;

	typedef struct packed {
		logic [7:0] name_byte;
		logic       no_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic       accepted;
		logic [3:0] reason;
	} out_item_t;

	// One request after classification, as it travels through the queue.
	typedef struct packed {
		logic [7:0] upper;
		logic       has_byte;
		logic       last;
		logic       is_slash;
		logic       is_dot;
		logic       is_space;
		logic       is_nul;
		logic       is_colon;
	} cls_item_t;

endpackage

>>> rtl/archive_entry_name_guard.sv
// Archive entry name guard, top level: at most one name byte per request, one verdict per name.
// Throughput one request per cycle while in_stall is low. The verdict is registered at the
// edge that pops the last request of a name from the queue. A stalled output holds only a
// request that ends a name; behind it the queue fills and the front stalls. Reset clears the
// queue pointers, the name state and the output valid, and sets max_name_len to 4096.
// Depends on aeng_pkg, aeng_front, aeng_queue and aeng_back.
module archive_entry_name_guard import aeng_pkg::*; #(
	parameter int NAME_LIMIT = NAME_LIMIT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [MAX_LEN_W-1:0] cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item
);

	logic [MAX_LEN_W-1:0] max_name_len_q;
	logic                 q_full;
	logic                 q_push;
	cls_item_t            q_in;
	logic                 q_pop;
	logic                 q_head_valid;
	cls_item_t            q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_name_len_q <= cfg_wdata;
		end
	end

	aeng_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	aeng_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_data  (q_head)
	);

	aeng_back #(
		.NAME_LIMIT (NAME_LIMIT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.max_name_len (max_name_len_q),
		.head_valid   (q_head_valid),
		.head_data    (q_head),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_item     (out_item)
	);

endmodule

>>> rtl/aeng_front.sv
// Front end of the archive entry name guard: takes requests, folds case and
// backslash, flags the special characters and pushes into the queue.
// Depends on aeng_pkg.
module aeng_front import aeng_pkg::*; (
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	input  logic      q_full,
	output logic      q_push,
	output cls_item_t q_data
);

	logic [7:0] ch;

	always_comb begin
		ch = (in_item.name_byte == CH_BSLASH) ? CH_SLASH : in_item.name_byte;
		q_data.upper    = (ch >= CH_LOW_A && ch <= CH_LOW_Z) ? ch - CASE_GAP : ch;
		q_data.has_byte = !in_item.no_byte;
		q_data.last     = in_item.last;
		q_data.is_slash = (ch == CH_SLASH);
		q_data.is_dot   = (ch == CH_DOT);
		q_data.is_space = (ch == CH_SPACE);
		q_data.is_nul   = (ch == CH_NUL);
		q_data.is_colon = (ch == CH_COLON);
	end

	assign in_stall = q_full;
	// drop byteless requests that do not end a name
	assign q_push = in_valid && !q_full && (in_item.last || !in_item.no_byte);

endmodule

>>> rtl/aeng_queue.sv
// Short queue between front and back of the archive entry name guard.
// Register file with read and write pointers and a fill count.
// Depends on aeng_pkg.
module aeng_queue import aeng_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_item_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output cls_item_t head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cls_item_t        slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop)
		else $error("queue popped while empty");

endmodule

>>> rtl/aeng_back.sv
// Back end of the archive entry name guard: walks the classified bytes,
// tracks name and component state and registers one verdict per name.
// Depends on aeng_pkg.
module aeng_back import aeng_pkg::*; #(
	parameter int NAME_LIMIT = NAME_LIMIT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [MAX_LEN_W-1:0] max_name_len,
	input  logic                 head_valid,
	input  cls_item_t            head_data,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item
);

	localparam int LEN_W = $clog2(NAME_LIMIT + 2);
	localparam int CMP_W = (LEN_W > MAX_LEN_W) ? LEN_W : MAX_LEN_W;
	localparam logic [LEN_W-1:0] LEN_CAP   = LEN_W'(NAME_LIMIT);
	localparam logic [CMP_W-1:0] LIMIT_CMP = CMP_W'(NAME_LIMIT);

	typedef struct packed {
		logic [1:0]      len;
		logic            all_dots;
		logic            last_dot;
		logic            last_space;
		logic [3:0][7:0] stem;
		logic [2:0]      stem_len;
		logic            stem_closed;
	} comp_t;

	localparam comp_t COMP_CLEAR = '{len: 2'd0, all_dots: 1'b1, last_dot: 1'b0,
		last_space: 1'b0, stem: '0, stem_len: 3'd0, stem_closed: 1'b0};

	function automatic logic is_device(input comp_t c);
		logic [23:0] head3;
		logic        three;
		logic        four;
		head3 = {c.stem[0], c.stem[1], c.stem[2]};
		three = (c.stem_len == 3'd3) && (head3 == DEV_CON || head3 == DEV_PRN ||
			head3 == DEV_AUX || head3 == DEV_NUL);
		four  = (c.stem_len == 3'd4) && c.stem[3] >= CH_ONE && c.stem[3] <= CH_NINE &&
			(head3 == DEV_COM || head3 == DEV_LPT);
		return three || four;
	endfunction

	function automatic fault_t comp_code(input comp_t c);
		fault_t f;
		f = FAULT_NONE;
		if (c.len != 2'd0) begin
			if (c.len == 2'd2 && c.all_dots) begin
				f = FAULT_PARENT;
			end else if ((c.last_dot || c.last_space) && !(c.len == 2'd1 && c.last_dot)) begin
				f = FAULT_TRAILING;
			end else if (is_device(c)) begin
				f = FAULT_DEVICE;
			end
		end
		return f;
	endfunction

	logic [LEN_W-1:0] name_len_q, n_name_len;
	logic             saw_nul_q, n_saw_nul;
	logic             saw_abs_q, n_saw_abs;
	logic             saw_drive_q, n_saw_drive;
	fault_t           fault_q, n_fault, fin_fault;
	comp_t            comp_q, n_comp;
	logic             out_valid_q;
	out_item_t        out_q;
	logic [CMP_W-1:0] limit;
	reason_t          reason;

	assign limit = (CMP_W'(max_name_len) < LIMIT_CMP) ? CMP_W'(max_name_len) : LIMIT_CMP;

	always_comb begin
		n_name_len  = name_len_q;
		n_saw_nul   = saw_nul_q;
		n_saw_abs   = saw_abs_q;
		n_saw_drive = saw_drive_q;
		n_fault     = fault_q;
		n_comp      = comp_q;
		if (head_data.has_byte) begin
			if (name_len_q == '0 && head_data.is_slash) begin
				n_saw_abs = 1'b1;
			end
			if (name_len_q == LEN_W'(1) && head_data.is_colon) begin
				n_saw_drive = 1'b1;
			end
			if (head_data.is_nul) begin
				n_saw_nul = 1'b1;
			end
			if (name_len_q <= LEN_CAP) begin
				n_name_len = name_len_q + 1'b1;
			end
			if (head_data.is_slash) begin
				if (fault_q == FAULT_NONE) begin
					n_fault = comp_code(comp_q);
				end
				n_comp = COMP_CLEAR;
			end else begin
				if (comp_q.len != 2'd3) begin
					n_comp.len = comp_q.len + 1'b1;
				end
				n_comp.all_dots   = comp_q.all_dots && head_data.is_dot;
				n_comp.last_dot   = head_data.is_dot;
				n_comp.last_space = head_data.is_space;
				if (!comp_q.stem_closed) begin
					if (head_data.is_dot) begin
						n_comp.stem_closed = 1'b1;
					end else begin
						for (int i = 0; i < 4; i++) begin
							if (comp_q.stem_len == 3'(i)) begin
								n_comp.stem[i] = head_data.upper;
							end
						end
						if (comp_q.stem_len != 3'd5) begin
							n_comp.stem_len = comp_q.stem_len + 1'b1;
						end
					end
				end
			end
		end

		// close the open component at the end of the name
		fin_fault = (n_fault == FAULT_NONE) ? comp_code(n_comp) : n_fault;

		if (n_name_len == '0) begin
			reason = REASON_EMPTY;
		end else if (CMP_W'(n_name_len) > limit) begin
			reason = REASON_TOO_LONG;
		end else if (n_saw_nul) begin
			reason = REASON_NUL;
		end else if (n_saw_abs) begin
			reason = REASON_ABSOLUTE;
		end else if (n_saw_drive) begin
			reason = REASON_DRIVE;
		end else begin
			case (fin_fault)
				FAULT_PARENT:   reason = REASON_PARENT;
				FAULT_TRAILING: reason = REASON_TRAILING;
				FAULT_DEVICE:   reason = REASON_DEVICE;
				default:        reason = REASON_OK;
			endcase
		end
	end

	// a byte with no verdict never waits on the output register
	assign pop = head_valid && (!head_data.last || !out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_len_q  <= '0;
			saw_nul_q   <= 1'b0;
			saw_abs_q   <= 1'b0;
			saw_drive_q <= 1'b0;
			fault_q     <= FAULT_NONE;
			comp_q      <= COMP_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head_data.last) begin
					name_len_q  <= '0;
					saw_nul_q   <= 1'b0;
					saw_abs_q   <= 1'b0;
					saw_drive_q <= 1'b0;
					fault_q     <= FAULT_NONE;
					comp_q      <= COMP_CLEAR;
				end else begin
					name_len_q  <= n_name_len;
					saw_nul_q   <= n_saw_nul;
					saw_abs_q   <= n_saw_abs;
					saw_drive_q <= n_saw_drive;
					fault_q     <= n_fault;
					comp_q      <= n_comp;
				end
			end
			if (pop && head_data.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_data.last) begin
			out_q.accepted <= (reason == REASON_OK);
			out_q.reason   <= reason;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_clear_after_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head_data.last |=> name_len_q == '0 && fault_q == FAULT_NONE)
		else $error("name state not cleared after verdict");

	a_stem_needs_comp: assert property (@(posedge clk) disable iff (!arst_n)
		comp_q.len == 2'd0 |-> comp_q.stem_len == 3'd0 && !comp_q.stem_closed)
		else $error("stem state without an open component");

	a_drive_position: assert property (@(posedge clk) disable iff (!arst_n)
		saw_drive_q |-> name_len_q >= LEN_W'(2))
		else $error("drive flag set before second byte");

endmodule
